### sv/rcb_pkg.sv
// shared types, constants and cosine table entry function for the raised-cosine bump height query
`default_nettype none
package rcb_pkg;
    localparam int MAX_BUMPS_DEF = 64;
    localparam int COS_DEPTH_DEF = 1024;
    localparam int COORD_W = 22;
    localparam int RAD_W = 16;
    localparam int HGT_W = 16;
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } cmd_t;

    function automatic logic [15:0] cos_entry(input int k, input int depth, input real step);
        real c;
        real v;
        int iv;
        c = $cos(step * k);
        v = 65535.0 * 0.5 * (1.0 + c);
        iv = int'($floor(v + 0.5));
        if (2 * k == depth)
        begin
            iv = 32768;
        end
        if (iv > 65535)
        begin
            iv = 65535;
        end
        if (iv < 0)
        begin
            iv = 0;
        end
        return iv[15:0];
    endfunction
endpackage
`default_nettype wire

### sv/raised_cosine_bump_height_query.sv
// top level of the raised-cosine bump height query
//  channel | handshake    | fields
//  input   | push / full  | func, pos_x, pos_y, bump_radius_in, bump_height_in
//  result  | pop / empty  | surface_height, status
// clear, add and unused codes are answered via the command queue and the
// result register; a query walks stored bumps one at a time: covered ones
// use a 24-step square root and 42-step divider, uncovered ones skip them
// a two-entry command queue lets clears and adds run ahead of the evaluator
// full stays high from a query's acceptance until its result is registered
// reset empties the table; bump storage is not cleared
`default_nettype none
module raised_cosine_bump_height_query #(
    parameter int MAX_BUMPS = rcb_pkg::MAX_BUMPS_DEF,
    parameter int COS_TABLE_DEPTH = rcb_pkg::COS_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [rcb_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [rcb_pkg::COORD_W-1:0]  pos_x,
    input  wire logic signed [rcb_pkg::COORD_W-1:0]  pos_y,
    input  wire logic [rcb_pkg::RAD_W-1:0]           bump_radius_in,
    input  wire logic [rcb_pkg::HGT_W-1:0]           bump_height_in,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [rcb_pkg::HGT_W-1:0]                surface_height,
    output logic                                     status
);
    localparam int AW = (MAX_BUMPS > 1) ? $clog2(MAX_BUMPS) : 1;
    localparam int CW = $clog2(MAX_BUMPS + 1);

    logic wr_en, cmd_valid, cmd_flag, cmd_take, qry_done;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] count;
    rcb_pkg::cmd_t cmd;
    logic signed [rcb_pkg::COORD_W-1:0] cx, cy;
    logic [rcb_pkg::RAD_W-1:0] rad;
    logic [rcb_pkg::HGT_W-1:0] pk;

    rcb_front #(.MAX_BUMPS(MAX_BUMPS)) u_front (
        .clk, .rst_n, .push, .full, .func, .pos_x, .pos_y,
        .wr_en, .wr_addr, .count, .cmd_valid, .cmd,
        .cmd_full_flag(cmd_flag), .cmd_take, .qry_done
    );

    rcb_ram #(.WIDTH(rcb_pkg::COORD_W), .DEPTH(MAX_BUMPS)) u_cx (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(pos_x), .raddr(rd_addr), .rdata(cx)
    );
    rcb_ram #(.WIDTH(rcb_pkg::COORD_W), .DEPTH(MAX_BUMPS)) u_cy (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(pos_y), .raddr(rd_addr), .rdata(cy)
    );
    rcb_ram #(.WIDTH(rcb_pkg::RAD_W), .DEPTH(MAX_BUMPS)) u_rad (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(bump_radius_in), .raddr(rd_addr),
        .rdata(rad)
    );
    rcb_ram #(.WIDTH(rcb_pkg::HGT_W), .DEPTH(MAX_BUMPS)) u_pk (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(bump_height_in), .raddr(rd_addr),
        .rdata(pk)
    );

    rcb_back #(.MAX_BUMPS(MAX_BUMPS), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd, .cmd_full_flag(cmd_flag), .cmd_take, .qry_done,
        .count, .rd_addr, .cx, .cy, .rad, .pk, .empty, .pop, .surface_height, .status
    );
endmodule
`default_nettype wire

### sv/rcb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/rcb_front.sv
// input stage: accepts transactions, handles clear and add, queues commands
`default_nettype none
module rcb_front #(
    parameter int MAX_BUMPS = rcb_pkg::MAX_BUMPS_DEF,
    localparam int AW = (MAX_BUMPS > 1) ? $clog2(MAX_BUMPS) : 1,
    localparam int CW = $clog2(MAX_BUMPS + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [rcb_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [rcb_pkg::COORD_W-1:0]  pos_x,
    input  wire logic signed [rcb_pkg::COORD_W-1:0]  pos_y,
    output logic                                     wr_en,
    output logic [AW-1:0]                            wr_addr,
    output logic [CW-1:0]                            count,
    output logic                                     cmd_valid,
    output rcb_pkg::cmd_t                            cmd,
    output logic                                     cmd_full_flag,
    input  wire logic                                cmd_take,
    input  wire logic                                qry_done
);
    localparam int QD = 2;
    rcb_pkg::cmd_t q_reg [QD];
    logic q_flag_reg [QD];
    logic [1:0] q_cnt_reg;
    logic q_rd_reg, q_wr_reg;
    logic [CW-1:0] count_reg;
    logic qry_pend_reg;
    logic acc, tbl_full;

    assign full = (q_cnt_reg == 2'(QD)) || qry_pend_reg;
    assign acc = push && !full;
    assign tbl_full = (count_reg == CW'(MAX_BUMPS));
    assign wr_en = acc && func == rcb_pkg::FUNC_ADD && !tbl_full;
    assign wr_addr = count_reg[AW-1:0];
    assign count = count_reg;
    assign cmd_valid = q_cnt_reg != 2'd0;
    assign cmd = q_reg[q_rd_reg];
    assign cmd_full_flag = q_flag_reg[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[q_wr_reg].func <= func;
            q_reg[q_wr_reg].pos_x <= pos_x;
            q_reg[q_wr_reg].pos_y <= pos_y;
            q_flag_reg[q_wr_reg] <= (func == rcb_pkg::FUNC_ADD) && tbl_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_rd_reg <= 1'b0;
            q_wr_reg <= 1'b0;
            count_reg <= '0;
            qry_pend_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                q_wr_reg <= !q_wr_reg;
                if (func == rcb_pkg::FUNC_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (wr_en)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (acc && func == rcb_pkg::FUNC_QUERY)
            begin
                qry_pend_reg <= 1'b1;
            end
            else if (qry_done)
            begin
                qry_pend_reg <= 1'b0;
            end
            if (cmd_take)
            begin
                q_rd_reg <= !q_rd_reg;
            end
            q_cnt_reg <= q_cnt_reg + 2'(acc) - 2'(cmd_take);
        end
    end
endmodule
`default_nettype wire

### sv/rcb_back.sv
// evaluator: scans stored bumps for a query, computes profile, one-entry result register
`default_nettype none
module rcb_back #(
    parameter int MAX_BUMPS = rcb_pkg::MAX_BUMPS_DEF,
    parameter int COS_TABLE_DEPTH = rcb_pkg::COS_DEPTH_DEF,
    localparam int AW = (MAX_BUMPS > 1) ? $clog2(MAX_BUMPS) : 1,
    localparam int CW = $clog2(MAX_BUMPS + 1),
    localparam int KW = $clog2(COS_TABLE_DEPTH)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    input  wire rcb_pkg::cmd_t                      cmd,
    input  wire logic                               cmd_full_flag,
    output logic                                    cmd_take,
    output logic                                    qry_done,
    input  wire logic [CW-1:0]                      count,
    output logic [AW-1:0]                           rd_addr,
    input  wire logic signed [rcb_pkg::COORD_W-1:0] cx,
    input  wire logic signed [rcb_pkg::COORD_W-1:0] cy,
    input  wire logic [rcb_pkg::RAD_W-1:0]          rad,
    input  wire logic [rcb_pkg::HGT_W-1:0]          pk,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [rcb_pkg::HGT_W-1:0]               surface_height,
    output logic                                    status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIST = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_MUL = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;
    localparam logic [2:0] S_ADDR = 3'd7;

    typedef logic [15:0] cos_lut_t [COS_TABLE_DEPTH];
    localparam real COS_STEP = 3.14159265358979323846 / COS_TABLE_DEPTH;

    function automatic cos_lut_t build_cos_lut();
        cos_lut_t t;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            t[k] = rcb_pkg::cos_entry(k, COS_TABLE_DEPTH, COS_STEP);
        end
        return t;
    endfunction

    localparam cos_lut_t COS_LUT = build_cos_lut();

    logic [2:0] st_reg;
    logic [CW-1:0] idx_reg;
    logic signed [rcb_pkg::COORD_W-1:0] px_reg, py_reg;
    logic [46:0] dx2_reg, dy2_reg;
    logic [47:0] d2_reg;
    logic [47:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0] step_reg;
    logic [40:0] num_reg;
    logic [40:0] drem_reg;
    logic [15:0] quo_reg;
    logic [5:0] dstep_reg;
    logic [rcb_pkg::RAD_W-1:0] r_reg;
    logic [rcb_pkg::HGT_W-1:0] pk_reg;
    logic [15:0] w_reg;
    logic [rcb_pkg::HGT_W-1:0] best_reg;
    logic [rcb_pkg::HGT_W-1:0] res_h_reg;
    logic res_s_reg, res_v_reg;
    logic mul_ph_reg;

    logic signed [rcb_pkg::COORD_W:0] dx, dy;
    logic [31:0] r2;
    logic [47:0] trial;
    logic [47:0] rem_sh;
    logic [41:0] dtrial;
    logic [KW-1:0] kidx;
    logic [31:0] prod;
    logic last_bump;

    assign dx = (rcb_pkg::COORD_W+1)'(px_reg) - (rcb_pkg::COORD_W+1)'(cx);
    assign dy = (rcb_pkg::COORD_W+1)'(py_reg) - (rcb_pkg::COORD_W+1)'(cy);
    assign r2 = r_reg * r_reg;
    assign rem_sh = {rem_reg[45:0], d2_reg[47:46]};
    assign trial = {22'd0, root_reg, 2'b01};
    assign dtrial = {drem_reg, num_reg[40]};
    assign kidx = quo_reg[15 -: KW];
    assign prod = pk_reg * w_reg;
    assign last_bump = (idx_reg + CW'(1) >= count);

    assign rd_addr = idx_reg[AW-1:0];
    assign cmd_take = (st_reg == S_IDLE) && cmd_valid && !res_v_reg;
    assign qry_done = (cmd_take && cmd.func == rcb_pkg::FUNC_QUERY && count == '0)
                      || (st_reg == S_OUT && last_bump && !res_v_reg);
    assign empty = !res_v_reg;
    assign surface_height = res_h_reg;
    assign status = res_s_reg;

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                px_reg <= cmd.pos_x;
                py_reg <= cmd.pos_y;
                best_reg <= '0;
            end
            S_READ:
            begin
                r_reg <= rad;
                pk_reg <= pk;
                dx2_reg <= 47'($signed(dx) * $signed(dx));
                dy2_reg <= 47'($signed(dy) * $signed(dy));
            end
            S_DIST:
            begin
                d2_reg <= 48'(dx2_reg) + 48'(dy2_reg);
                rem_reg <= '0;
                root_reg <= '0;
            end
            S_SQRT:
            begin
                if (step_reg == 5'd0 && (d2_reg >= 48'(r2) || r_reg == '0))
                begin
                    rem_reg <= rem_reg;
                end
                else if (rem_sh >= trial)
                begin
                    rem_reg <= rem_sh - trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
                if (!(step_reg == 5'd0 && (d2_reg >= 48'(r2) || r_reg == '0)))
                begin
                    d2_reg <= {d2_reg[45:0], 2'b00};
                end
                num_reg <= {1'b0, root_reg, 16'd0};
                drem_reg <= '0;
            end
            S_DIV:
            begin
                if (dstep_reg == 6'd0)
                begin
                    num_reg <= {1'b0, root_reg, 16'd0};
                    drem_reg <= '0;
                end
                else
                begin
                    num_reg <= {num_reg[39:0], 1'b0};
                    if (dtrial >= 42'(r_reg))
                    begin
                        drem_reg <= 41'(dtrial - 42'(r_reg));
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dtrial[40:0];
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                end
            end
            S_MUL:
            begin
                if (!mul_ph_reg)
                begin
                    w_reg <= COS_LUT[kidx];
                end
                else if (prod[31:16] > best_reg)
                begin
                    best_reg <= prod[31:16];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            idx_reg <= '0;
            step_reg <= '0;
            dstep_reg <= '0;
            mul_ph_reg <= 1'b0;
            res_v_reg <= 1'b0;
            res_h_reg <= '0;
            res_s_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_v_reg)
            begin
                res_v_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        idx_reg <= '0;
                        if (cmd.func == rcb_pkg::FUNC_QUERY && count != '0)
                        begin
                            st_reg <= S_ADDR;
                        end
                        else
                        begin
                            res_v_reg <= 1'b1;
                            res_h_reg <= '0;
                            res_s_reg <= cmd_full_flag;
                        end
                    end
                end
                S_ADDR: st_reg <= S_READ;
                S_READ: st_reg <= S_DIST;
                S_DIST:
                begin
                    st_reg <= S_SQRT;
                    step_reg <= '0;
                end
                S_SQRT:
                begin
                    if (step_reg == 5'd0 && (d2_reg >= 48'(r2) || r_reg == '0))
                    begin
                        st_reg <= S_OUT;
                    end
                    else if (step_reg == 5'd23)
                    begin
                        st_reg <= S_DIV;
                        dstep_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_DIV:
                begin
                    if (dstep_reg == 6'd41)
                    begin
                        st_reg <= S_MUL;
                        mul_ph_reg <= 1'b0;
                    end
                    else
                    begin
                        dstep_reg <= dstep_reg + 6'd1;
                    end
                end
                S_MUL:
                begin
                    mul_ph_reg <= 1'b1;
                    if (mul_ph_reg)
                    begin
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (last_bump)
                    begin
                        if (!res_v_reg)
                        begin
                            res_v_reg <= 1'b1;
                            res_h_reg <= best_reg;
                            res_s_reg <= 1'b0;
                            st_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        st_reg <= S_ADDR;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/raised_cosine_bump_height_query_checker.sv
// checker: predicts bump field heights and compares every result transaction
module raised_cosine_bump_height_query_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic                               full,
    input  wire logic [rcb_pkg::FUNC_W-1:0]         func,
    input  wire logic signed [rcb_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [rcb_pkg::COORD_W-1:0] pos_y,
    input  wire logic [rcb_pkg::RAD_W-1:0]          bump_radius_in,
    input  wire logic [rcb_pkg::HGT_W-1:0]          bump_height_in,
    input  wire logic                               empty,
    input  wire logic                               pop,
    input  wire logic [rcb_pkg::HGT_W-1:0]          surface_height,
    input  wire logic                               status,
    output int                                      fail_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBUMP = rcb_pkg::MAX_BUMPS_DEF;
    localparam int NCOS = rcb_pkg::COS_DEPTH_DEF;

    typedef struct packed {
        logic [rcb_pkg::HGT_W-1:0] height;
        logic                      dropped;
    } answer_t;

    answer_t                            answers[$];
    logic [15:0]                        profile[NCOS];
    logic signed [rcb_pkg::COORD_W-1:0] cx[NBUMP];
    logic signed [rcb_pkg::COORD_W-1:0] cy[NBUMP];
    logic [rcb_pkg::RAD_W-1:0]          rad[NBUMP];
    logic [rcb_pkg::HGT_W-1:0]          peak[NBUMP];
    int                                 stored;

    assign pending = answers.size();

    initial
    begin
        real v;
        fail_count = 0;
        stored = 0;
        for (int k = 0; k < NCOS; k++)
        begin
            v = 32767.5 * (1.0 + $cos(3.14159265358979323846 * k / NCOS));
            profile[k] = (2 * k == NCOS) ? 16'd32768 : 16'(longint'($floor(v + 0.5)));
        end
    end

    function automatic longint unsigned root_floor(input longint unsigned a);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > a)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (a >= res + bitv)
            begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [rcb_pkg::HGT_W-1:0] field_height(
        input logic signed [rcb_pkg::COORD_W-1:0] px,
        input logic signed [rcb_pkg::COORD_W-1:0] py);
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned r;
        longint unsigned q;
        longint unsigned k;
        longint unsigned z;
        longint unsigned best;
        best = 0;
        for (int i = 0; i < stored; i++)
        begin
            dx = longint'(px) - longint'(cx[i]);
            dy = longint'(py) - longint'(cy[i]);
            d2 = dx * dx + dy * dy;
            r = rad[i];
            if (d2 < r * r)
            begin
                q = (root_floor(d2) << 16) / r;
                k = (q * NCOS) >> 16;
                if (k >= NCOS)
                    k = NCOS - 1;
                z = (longint'(peak[i]) * profile[k]) >> 16;
                if (z > best)
                    best = z;
            end
        end
        return best[rcb_pkg::HGT_W-1:0];
    endfunction

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        answer_t a;
        answer_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                a = '0;
                case (func)
                    rcb_pkg::FUNC_CLEAR: stored = 0;
                    rcb_pkg::FUNC_ADD:
                    begin
                        if (stored < NBUMP)
                        begin
                            cx[stored] = pos_x;
                            cy[stored] = pos_y;
                            rad[stored] = bump_radius_in;
                            peak[stored] = bump_height_in;
                            stored++;
                        end
                        else
                        begin
                            a.dropped = 1'b1;
                        end
                    end
                    rcb_pkg::FUNC_QUERY: a.height = field_height(pos_x, pos_y);
                    default: ;
                endcase
                answers = {answers, a};
            end
            if (pop && !empty)
            begin
                if (answers.size() == 0)
                begin
                    report("result transaction with nothing outstanding");
                end
                else
                begin
                    want = answers.pop_front();
                    if (surface_height !== want.height)
                        report($sformatf("surface_height %0d, wanted %0d",
                                         surface_height, want.height));
                    if (status !== want.dropped)
                        report($sformatf("status %0b, wanted %0b", status, want.dropped));
                end
            end
        end
    end
endmodule

### tb/raised_cosine_bump_height_query_test.sv
// testbench top: drives bump table transactions and gives the verdict
module raised_cosine_bump_height_query_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                               clk;
    logic                               rst_n;
    logic                               push;
    logic                               full;
    logic [rcb_pkg::FUNC_W-1:0]         func;
    logic signed [rcb_pkg::COORD_W-1:0] pos_x;
    logic signed [rcb_pkg::COORD_W-1:0] pos_y;
    logic [rcb_pkg::RAD_W-1:0]          bump_radius_in;
    logic [rcb_pkg::HGT_W-1:0]          bump_height_in;
    logic                               empty;
    logic                               pop;
    logic [rcb_pkg::HGT_W-1:0]          surface_height;
    logic                               status;
    int                                 fail_count;
    int                                 pending;
    logic                               steady;
    int                                 sent;
    int                                 bx[$];
    int                                 by[$];
    int                                 br[$];

    raised_cosine_bump_height_query u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .pos_x(pos_x), .pos_y(pos_y), .bump_radius_in(bump_radius_in),
        .bump_height_in(bump_height_in), .empty(empty), .pop(pop),
        .surface_height(surface_height), .status(status)
    );

    raised_cosine_bump_height_query_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .pos_x(pos_x), .pos_y(pos_y), .bump_radius_in(bump_radius_in),
        .bump_height_in(bump_height_in), .empty(empty), .pop(pop),
        .surface_height(surface_height), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        pop <= steady ? 1'b1 : ($urandom_range(99) >= 23);
    end

    initial
    begin
        #1s;
        $display("raised_cosine_bump_height_query_test failed");
        $finish;
    end

    task automatic send(input logic [rcb_pkg::FUNC_W-1:0] f, input int x, input int y,
                        input int r, input int h);
        push <= 1'b1;
        func <= f;
        pos_x <= x[rcb_pkg::COORD_W-1:0];
        pos_y <= y[rcb_pkg::COORD_W-1:0];
        bump_radius_in <= r[rcb_pkg::RAD_W-1:0];
        bump_height_in <= h[rcb_pkg::HGT_W-1:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
        if (!steady && $urandom_range(99) < 23)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic add_bump(input int x, input int y, input int r, input int h);
        send(rcb_pkg::FUNC_ADD, x, y, r, h);
        if (bx.size() < rcb_pkg::MAX_BUMPS_DEF)
        begin
            bx = {bx, x};
            by = {by, y};
            br = {br, r};
        end
    endtask

    task automatic clear_table();
        send(rcb_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
        bx.delete();
        by.delete();
        br.delete();
    endtask

    task automatic probe();
        int b;
        int r;
        int sel;
        if (bx.size() == 0 || $urandom_range(9) == 0)
        begin
            send(rcb_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            b = $urandom_range(bx.size() - 1);
            r = br[b];
            sel = $urandom_range(9);
            if (sel == 0)
                send(rcb_pkg::FUNC_QUERY, bx[b], by[b], 0, 0);
            else if (sel == 1)
                send(rcb_pkg::FUNC_QUERY, bx[b] + r, by[b], 0, 0);
            else
                send(rcb_pkg::FUNC_QUERY, bx[b] + $urandom_range(2 * r) - r,
                     by[b] + $urandom_range(2 * r) - r, 0, 0);
        end
    endtask

    initial
    begin
        int n;
        int big;
        rst_n = 1'b0;
        push = 1'b0;
        func = rcb_pkg::FUNC_CLEAR;
        pos_x = '0;
        pos_y = '0;
        bump_radius_in = '0;
        bump_height_in = '0;
        steady = 1'b0;
        sent = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send(rcb_pkg::FUNC_QUERY, 0, 0, 0, 0);
        add_bump(0, 0, 0, 65535);
        send(rcb_pkg::FUNC_QUERY, 0, 0, 0, 0);
        clear_table();
        add_bump(-2097152, 2097151, 65535, 65535);
        send(rcb_pkg::FUNC_QUERY, -2097152, 2097151, 0, 0);
        send(rcb_pkg::FUNC_QUERY, -2097152 + 65535, 2097151, 0, 0);
        send(rcb_pkg::FUNC_QUERY, -2097152 + 65534, 2097151, 0, 0);
        add_bump(2097151, -2097152, 1, 0);
        send(rcb_pkg::FUNC_QUERY, 2097151, -2097152, 0, 0);
        add_bump(0, 0, 1000, 65535);
        send(rcb_pkg::FUNC_QUERY, 500, 0, 0, 0);
        send(rcb_pkg::FUNC_QUERY, 0, 999, 0, 0);
        send(rcb_pkg::FUNC_QUERY, 0, 1000, 0, 0);
        send(rcb_pkg::FUNC_NONE, -1, -1, 65535, 65535);
        clear_table();
        send(rcb_pkg::FUNC_QUERY, 0, 0, 0, 0);
        drain();

        while (sent < 1700)
        begin
            steady = (sent >= 700 && sent < 1000);
            if ($urandom_range(99) < 85)
            begin
                big = ($urandom_range(99) < 4);
                n = big ? $urandom_range(64, 70) : $urandom_range(1, 6);
                clear_table();
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(1))
                        add_bump($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                                 $urandom_range(1, 3000), $urandom_range(65535));
                    else
                        add_bump($urandom, $urandom, $urandom_range(65535),
                                 $urandom_range(65535));
                end
                n = big ? 2 : $urandom_range(2, 8);
                for (int i = 0; i < n; i++)
                    probe();
            end
            else
            begin
                n = $urandom_range(3);
                if (n == rcb_pkg::FUNC_CLEAR)
                    clear_table();
                else if (n == rcb_pkg::FUNC_ADD)
                    add_bump($urandom, $urandom, $urandom, $urandom);
                else
                    send(n[rcb_pkg::FUNC_W-1:0], $urandom, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(19) == 0 || (sent > 400 && sent < 420))
                drain();
        end

        steady = 1'b0;
        drain();
        repeat (200)
            @(posedge clk);
        if (fail_count == 0)
            $display("raised_cosine_bump_height_query_test passed");
        else
            $display("raised_cosine_bump_height_query_test failed");
        $finish;
    end
endmodule

### sim.f
sv/rcb_pkg.sv
sv/rcb_ram.sv
sv/rcb_front.sv
sv/rcb_back.sv
sv/raised_cosine_bump_height_query.sv
tb/raised_cosine_bump_height_query_checker.sv
tb/raised_cosine_bump_height_query_test.sv
